### sv/sitoa_pkg.sv
// Shared types and constants for the signed integer to decimal ASCII converter.
package sitoa_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_MINUS = 8'd45;

   function automatic int dec_digits(input int w);
      logic [63:0] m;
      int          n;
      m = 64'd1 << (w - 1);
      n = 0;
      while (m != 64'd0) begin
         m = m / 64'd10;
         n = n + 1;
      end
      return n;
   endfunction

   localparam int MAX_DIGITS = dec_digits(VALUE_WIDTH);

   typedef struct packed {
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
   } sitoa_entry_type;

endpackage

### sv/sitoa_front.sv
// Front end: takes a signed value and splits it into sign and unsigned magnitude.
module sitoa_front (
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sitoa_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                               push_valid,
   input  logic                               push_ready,
   output sitoa_pkg::sitoa_entry_type         push_entry
);
   import sitoa_pkg::*;

   logic neg;

   assign neg              = req_value[VALUE_WIDTH-1];
   assign push_entry.neg   = neg;
   assign push_entry.mag   = neg ? (~req_value + VALUE_WIDTH'(1)) : req_value;
   assign push_valid       = req_valid;
   assign req_ready        = push_ready;

endmodule

### sv/sitoa_fifo.sv
// Short queue between the front end and the digit engine.
module sitoa_fifo (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push_valid,
   output logic                        push_ready,
   input  sitoa_pkg::sitoa_entry_type  push_entry,
   output logic                        pop_valid,
   input  logic                        pop_ready,
   output sitoa_pkg::sitoa_entry_type  pop_entry
);
   import sitoa_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sitoa_entry_type   mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != CNT_W'(0));
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_entry  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? PTR_W'(0) : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/sitoa_back.sv
// Digit engine: divides by ten with a reciprocal multiply, then emits the sign if negative and the digits MSB first.
module sitoa_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        pop_valid,
   output logic                        pop_ready,
   input  sitoa_pkg::sitoa_entry_type  pop_entry,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [7:0]                  rsp_character,
   output logic                        rsp_last
);
   import sitoa_pkg::*;

   localparam int MAG_W  = VALUE_WIDTH;
   localparam int PROD_W = 2 * MAG_W;
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int IDX_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
   localparam logic [MAG_W+3:0] POW   = {1'b1, {(MAG_W + 3){1'b0}}};
   localparam logic [MAG_W+3:0] RECIP_WIDE = (POW + (MAG_W + 4)'(9)) / (MAG_W + 4)'(10);
   localparam logic [MAG_W-1:0] RECIP = RECIP_WIDE[MAG_W-1:0];

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_DIV  = 5'b00100,
      ST_SIGN = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type          state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [PROD_W-1:0]  prod_ff, prod_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               neg_ff, neg_in;
   logic [3:0]         dig_ff [MAX_DIGITS];
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_char_ff, rsp_char_in;
   logic               rsp_last_ff, rsp_last_in;

   logic [MAG_W-1:0]   quot;
   logic [3:0]         q10_lo;
   logic [3:0]         digit;
   logic [CNT_W-1:0]   cnt_dec;
   logic [IDX_W-1:0]   wr_idx, rd_idx;
   logic               dig_we;
   logic               out_free;
   logic               out_load;

   assign quot     = MAG_W'(prod_ff >> (MAG_W + 3));
   assign q10_lo   = 4'({quot[0], 3'b000}) + 4'({quot[2:0], 1'b0});
   assign digit    = mag_ff[3:0] - q10_lo;
   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign wr_idx   = cnt_ff[IDX_W-1:0];
   assign rd_idx   = cnt_dec[IDX_W-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      mag_in      = mag_ff;
      prod_in     = prod_ff;
      cnt_in      = cnt_ff;
      neg_in      = neg_ff;
      dig_we      = 1'b0;
      out_load    = 1'b0;
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               mag_in   = pop_entry.mag;
               neg_in   = pop_entry.neg;
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = PROD_W'(mag_ff) * PROD_W'(RECIP);
            state_in = ST_DIV;
         end
         ST_DIV: begin
            dig_we = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            mag_in = quot;
            if (quot == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_SIGN: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = CHAR_MINUS;
               rsp_last_in = 1'b0;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load    = 1'b1;
               rsp_char_in = CHAR_ZERO + {4'b0000, dig_ff[rd_idx]};
               rsp_last_in = (cnt_ff == CNT_W'(1));
               cnt_in      = cnt_dec;
               if (cnt_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      if (dig_we) begin
         dig_ff[wr_idx] <= digit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_character = rsp_char_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

### sv/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_value (32b signed)
//   rsp      out        rsp_valid / rsp_ready  rsp_character (8b), rsp_last
//
// For each digit the digit engine multiplies by the reciprocal of ten, then takes the remainder;
// it then emits the optional sign and the digits, one character per cycle unless rsp stalls.
// The front end and a two-entry queue keep accepting while the engine works, until the queue is full.
// Reset is synchronous and clears all control state; rsp stalls hold the output register.
module signed_int_to_decimal_ascii (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sitoa_pkg::VALUE_WIDTH-1:0]  req_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_character,
   output logic                               rsp_last
);
   import sitoa_pkg::*;

   logic             push_valid, push_ready;
   sitoa_entry_type  push_entry;
   logic             pop_valid, pop_ready;
   sitoa_entry_type  pop_entry;

   sitoa_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_value  (req_value),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   sitoa_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sitoa_back u_back (
      .clock         (clock),
      .reset         (reset),
      .pop_valid     (pop_valid),
      .pop_ready     (pop_ready),
      .pop_entry     (pop_entry),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

### sv/sitoa_checker.sv
// Port-level checks for the converter, bound to the top level.
module sitoa_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_character,
   input logic       rsp_last
);
   import sitoa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_character) && $stable(rsp_last))
      else $error("rsp transaction changed while stalled");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_character == CHAR_MINUS) ||
                    (rsp_character >= CHAR_ZERO && rsp_character <= CHAR_ZERO + 8'd9))
      else $error("rsp character is not a sign or digit");

   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_character == CHAR_MINUS |-> !rsp_last)
      else $error("sign character flagged last");

   a_minus_then_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_character == CHAR_MINUS |=>
         !(rsp_valid && rsp_character == CHAR_MINUS))
      else $error("sign character repeated");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (.*);

### verif/tb_signed_int_to_decimal_ascii.sv
// Testbench for the signed integer to decimal ASCII converter: predicted text vs. rsp stream.
`timescale 1ns / 100ps

module tb_signed_int_to_decimal_ascii;
   import sitoa_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int PHASE_ITEMS  = 40;

   typedef struct packed {
      logic [7:0] character;
      logic       last;
   } text_char_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [7:0]             rsp_character;
   logic                   rsp_last;

   text_char_type expected_text[$];
   int            send_idle_pct;
   int            rsp_stall_pct;
   int            error_count = 0;
   int            values_accepted = 0;
   int            chars_checked = 0;
   int            negatives_sent = 0;
   int            quiet_cycles = 0;

   signed_int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      error_count++;
   endtask

   // Decimal text of one value: optional '-', then digits, last flag on the final digit.
   function automatic void predict_decimal_text(input logic [VALUE_WIDTH-1:0] value);
      logic                   neg;
      logic [VALUE_WIDTH-1:0] mag;
      logic [7:0]             digits[$];
      text_char_type          c;
      neg = value[VALUE_WIDTH-1];
      mag = neg ? (~value + 1'b1) : value;
      do begin
         digits.push_front(CHAR_ZERO + 8'(mag % 10));
         mag = mag / 10;
      end while (mag != '0);
      if (neg) begin
         c.character = CHAR_MINUS;
         c.last = 1'b0;
         expected_text.push_back(c);
      end
      foreach (digits[i]) begin
         c.character = digits[i];
         c.last = (i == digits.size() - 1);
         expected_text.push_back(c);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Checks the rsp stream, predicts each accepted req transaction, and runs the watchdog.
   always @(posedge clock) begin
      text_char_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_text.size() == 0) begin
               report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                         rsp_character, rsp_last));
            end else begin
               want = expected_text.pop_front();
               if (rsp_character !== want.character)
                  report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                            rsp_character, want.character));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b (character 0x%02h)",
                                            rsp_last, want.last, want.character));
               chars_checked++;
            end
         end
         if (req_valid && req_ready) begin
            predict_decimal_text(req_value);
            values_accepted++;
            if (req_value[VALUE_WIDTH-1]) negatives_sent++;
         end
      end
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles, %0d characters outstanding",
                     IDLE_LIMIT, expected_text.size());
            $display("signed_int_to_decimal_ascii test failed");
            $finish;
         end
      end
   end

   task automatic send_value(input logic [VALUE_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (!req_ready);
   endtask

   // Value whose magnitude has nd decimal digits, with a random sign.
   function automatic logic [VALUE_WIDTH-1:0] value_with_digits(input int nd);
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mag;
      logic            neg;
      lo = 1;
      for (int i = 1; i < nd; i++) lo = lo * 10;
      hi = lo * 10 - 1;
      if (nd == 1) lo = 0;
      if (hi > 64'd2147483648) hi = 64'd2147483648;
      mag = 64'($urandom_range(32'(hi), 32'(lo)));
      neg = 1'($urandom_range(1));
      if (!neg && mag == 64'd2147483648) mag = 64'd2147483647;
      return neg ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
   endfunction

   task automatic test_boundary_values();
      logic [VALUE_WIDTH-1:0] values[$];
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      values = '{32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
                 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000,
                 32'd999999999, -32'sd999999999, 32'd1999999999, -32'sd1000000000,
                 32'd12345, -32'sd54321, 32'h5555_5555, 32'hAAAA_AAAA, 32'd1000000001};
      foreach (values[i]) send_value(values[i]);
   endtask

   task automatic test_digit_lengths();
      send_idle_pct = 65;
      rsp_stall_pct = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(value_with_digits($urandom_range(10, 1)));
   endtask

   task automatic test_full_range_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 65;
      for (int i = 0; i < PHASE_ITEMS; i++) send_value($urandom);
   endtask

   task automatic test_mixed_pressure();
      send_idle_pct = 27;
      rsp_stall_pct = 27;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
         if ($urandom_range(1)) send_value($urandom);
         else send_value(value_with_digits($urandom_range(10, 1)));
      end
   endtask

   task automatic test_burst_no_idle();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) send_value(value_with_digits($urandom_range(10, 1)));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_value = '0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_boundary_values();
      test_digit_lengths();
      test_full_range_backpressure();
      test_mixed_pressure();
      test_burst_no_idle();
      req_valid <= 1'b0;

      @(posedge clock);
      wait (expected_text.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_text.size() != 0)
         report_mismatch($sformatf("%0d characters never arrived", expected_text.size()));

      $display("Converted %0d values (%0d negative), checked %0d characters;",
               values_accepted, negatives_sent, chars_checked);
      $display("covered zero, both extremes, every digit count, and four idle/stall mixes.");
      if (error_count == 0) begin
         $display("signed_int_to_decimal_ascii test passed");
      end else begin
         $display("signed_int_to_decimal_ascii test failed");
      end
      $finish;
   end

endmodule
